// ===== rtl/alist_pkg.sv =====
`timescale 1ns / 1ps

package alist_pkg;

   // fixed field widths of the two channels
   localparam int KIND_WIDTH      = 2;
   localparam int KEY_IN_WIDTH    = 32;
   localparam int POS_WIDTH       = 7;
   localparam int INDEX_OUT_WIDTH = 6;
   localparam int COUNT_OUT_WIDTH = 7;

   // radix of one step of the first-match tree
   localparam int TREE_RADIX      = 8;
   localparam int TREE_RADIX_LOG2 = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic match;
      logic reduce;
      logic update;
   } alist_cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type req_kind;
      logic     rsp_free;
   } alist_status_type;

endpackage

// ===== rtl/alist_if.sv =====
`timescale 1ns / 1ps

interface alist_req_if;
   logic                                valid;
   logic                                ready;
   logic [alist_pkg::KIND_WIDTH-1:0]    kind;
   logic signed [alist_pkg::KEY_IN_WIDTH-1:0] key;
   logic [alist_pkg::POS_WIDTH-1:0]     position;

   modport source (output valid, output kind, output key, output position, input ready);
   modport sink (input valid, input kind, input key, input position, output ready);
endinterface

interface alist_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   failed;
   logic [alist_pkg::INDEX_OUT_WIDTH-1:0]  found_index;
   logic [alist_pkg::COUNT_OUT_WIDTH-1:0]  entry_count;

   modport source (output valid, output failed, output found_index, output entry_count,
                   input ready);
   modport sink (input valid, input failed, input found_index, input entry_count,
                 output ready);
endinterface

// ===== rtl/alist_ctrl.sv =====
`timescale 1ns / 1ps

module alist_ctrl #(
   parameter int LEVELS = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  alist_pkg::alist_status_type status,
   output alist_pkg::alist_cmd_type    cmd
);
   import alist_pkg::*;

   localparam int LVL_W = $clog2(LEVELS + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_REDUCE = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      level_in    = level_ff;
      cmd.capture = accept;
      cmd.match   = 1'b0;
      cmd.reduce  = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // insert and clear need no lookup
               if (status.req_kind == KIND_INSERT || status.req_kind == KIND_CLEAR) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            level_in  = '0;
            state_in  = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (level_ff == LVL_W'(LEVELS - 1)) begin
               state_in = ST_UPDATE;
            end else begin
               level_in = level_ff + LVL_W'(1);
            end
         end
         ST_UPDATE: begin
            // hold until the output register can take the result
            if (status.rsp_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

endmodule

// ===== rtl/alist_dpath.sv =====
`timescale 1ns / 1ps

module alist_dpath #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  alist_pkg::alist_cmd_type                    cmd,
   output alist_pkg::alist_status_type                 status,
   input  logic [alist_pkg::KIND_WIDTH-1:0]            req_kind,
   input  logic signed [alist_pkg::KEY_IN_WIDTH-1:0]   req_key,
   input  logic [alist_pkg::POS_WIDTH-1:0]             req_position,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic                                        rsp_failed,
   output logic [alist_pkg::INDEX_OUT_WIDTH-1:0]       rsp_found_index,
   output logic [alist_pkg::COUNT_OUT_WIDTH-1:0]       rsp_entry_count
);
   import alist_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH;
   localparam int LEVELS = (IDX_W + TREE_RADIX_LOG2 - 1) / TREE_RADIX_LOG2;
   localparam int NODES  = 1 << (TREE_RADIX_LOG2 * LEVELS);
   localparam int GROUPS = NODES / TREE_RADIX;

   // list cells
   logic [KEY_WIDTH-1:0] cell_ff [CAPACITY];
   logic [KEY_WIDTH-1:0] cell_in [CAPACITY];
   logic [KEY_WIDTH-1:0] up_src  [CAPACITY];
   logic [KEY_WIDTH-1:0] dn_src  [CAPACITY];
   logic [CNT_W-1:0]     count_ff, count_in;

   // captured operation
   kind_type             kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [2*KEY_IN_WIDTH-1:0] key_wide;

   // first-match tree
   logic             node_hit_ff [NODES];
   logic             node_hit_in [NODES];
   logic [IDX_W-1:0] node_idx_ff [NODES];
   logic [IDX_W-1:0] node_idx_in [NODES];
   logic [NODES-1:0] match_pad;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_failed_ff, rsp_failed_in;
   logic [INDEX_OUT_WIDTH-1:0] rsp_index_ff, rsp_index_in;
   logic [COUNT_OUT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0] cnt_ext, pos_ext;
   logic             insert_ok, hit_found;
   logic [IDX_W-1:0] hit_idx, index_new;
   logic [CNT_W-1:0] count_new;
   logic             failed_new;
   logic [CNT_W+COUNT_OUT_WIDTH-1:0] count_wide;
   logic [IDX_W+INDEX_OUT_WIDTH-1:0] index_wide;

   assign status.req_kind = kind_type'(req_kind);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // sign-extend then keep the stored key width
   assign key_wide = {{KEY_IN_WIDTH{req_key[KEY_IN_WIDTH-1]}}, req_key};

   always_comb begin
      kind_in = kind_ff;
      key_in  = key_ff;
      pos_in  = pos_ff;
      if (cmd.capture) begin
         kind_in = kind_type'(req_kind);
         key_in  = key_wide[KEY_WIDTH-1:0];
         pos_in  = req_position;
      end
   end

   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign insert_ok = (pos_ext <= cnt_ext) && (count_ff != CNT_W'(CAPACITY));
   assign hit_found = node_hit_ff[0];
   assign hit_idx   = node_idx_ff[0];

   // neighbor taps for shifting up and down
   for (genvar i = 0; i < CAPACITY; i++) begin : g_tap
      if (i == 0) begin : g_first
         assign up_src[i] = key_ff;
      end else begin : g_up
         assign up_src[i] = cell_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign dn_src[i] = cell_ff[i];
      end else begin : g_dn
         assign dn_src[i] = cell_ff[i+1];
      end
   end

   // per-slot compare, padded out to the tree size
   for (genvar i = 0; i < NODES; i++) begin : g_match
      if (i < CAPACITY) begin : g_real
         assign match_pad[i] = (CMP_W'(i) < cnt_ext) && (cell_ff[i] == key_ff);
      end else begin : g_pad
         assign match_pad[i] = 1'b0;
      end
   end

   always_comb begin
      logic             grp_hit;
      logic [IDX_W-1:0] grp_idx;
      grp_hit = 1'b0;
      grp_idx = '0;
      for (int i = 0; i < NODES; i++) begin
         node_hit_in[i] = node_hit_ff[i];
         node_idx_in[i] = node_idx_ff[i];
      end
      if (cmd.match) begin
         for (int i = 0; i < NODES; i++) begin
            node_hit_in[i] = match_pad[i];
            node_idx_in[i] = IDX_W'(i);
         end
      end else if (cmd.reduce) begin
         // each group keeps its lowest hit
         for (int g = 0; g < GROUPS; g++) begin
            grp_hit = 1'b0;
            grp_idx = '0;
            for (int j = TREE_RADIX - 1; j >= 0; j--) begin
               if (node_hit_ff[g*TREE_RADIX + j]) begin
                  grp_hit = 1'b1;
                  grp_idx = node_idx_ff[g*TREE_RADIX + j];
               end
            end
            node_hit_in[g] = grp_hit;
            node_idx_in[g] = grp_idx;
         end
      end
   end

   // cell moves on update
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.update) begin
            if (kind_ff == KIND_INSERT && insert_ok) begin
               if (CMP_W'(i) == pos_ext) begin
                  cell_in[i] = key_ff;
               end else if (CMP_W'(i) > pos_ext && CMP_W'(i) <= cnt_ext) begin
                  cell_in[i] = up_src[i];
               end
            end else if (kind_ff == KIND_DELETE && hit_found) begin
               if (IDX_W'(i) >= hit_idx) begin
                  cell_in[i] = dn_src[i];
               end
            end
         end
      end
   end

   always_comb begin
      failed_new = 1'b0;
      index_new  = '0;
      count_new  = count_ff;
      unique case (kind_ff)
         KIND_INSERT: begin
            failed_new = !insert_ok;
            if (insert_ok) begin
               count_new = count_ff + CNT_W'(1);
            end
         end
         KIND_DELETE: begin
            failed_new = !hit_found;
            if (hit_found) begin
               count_new = count_ff - CNT_W'(1);
            end
         end
         KIND_SEARCH: begin
            failed_new = !hit_found;
            if (hit_found) begin
               index_new = hit_idx;
            end
         end
         KIND_CLEAR: begin
            count_new = '0;
         end
         default: begin
            failed_new = 1'b0;
         end
      endcase
   end

   assign count_in   = cmd.update ? count_new : count_ff;
   assign count_wide = {{COUNT_OUT_WIDTH{1'b0}}, count_new};
   assign index_wide = {{INDEX_OUT_WIDTH{1'b0}}, index_new};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_failed_in = rsp_failed_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.update) begin
         rsp_valid_in  = 1'b1;
         rsp_failed_in = failed_new;
         rsp_index_in  = index_wide[INDEX_OUT_WIDTH-1:0];
         rsp_count_in  = count_wide[COUNT_OUT_WIDTH-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      for (int i = 0; i < NODES; i++) begin
         node_hit_ff[i] <= node_hit_in[i];
         node_idx_ff[i] <= node_idx_in[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_failed      = rsp_failed_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/array_list_insert_delete_search.sv =====
`timescale 1ns / 1ps
// ordered list of up to CAPACITY keys with insert, delete by key, search and clear
// req_bus carries one operation per transaction (kind, key, position); rsp_bus
// returns exactly one result per operation (failed, found_index, entry_count)
// insert and clear go from acceptance straight to the update that loads the result;
// delete and search first load the compares, then take L = ceil(log2(CAPACITY) / 3)
// steps of the 8-way first-match tree (L = 2 at the default capacity) before their update
// one operation at a time: a new request is accepted only after the current one
// has loaded its result into the output register
// the result sits in an output register; a new request is taken while it waits
// if rsp_bus stalls, a finished operation holds before its update until the
// output register frees, so nothing is lost or repeated
// reset clears the entry count, the controller and the output valid; stored
// cells are not cleared, only slots below the count are ever compared
// no configuration registers

module array_list_insert_delete_search #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   alist_req_if.sink          req_bus,
   alist_rsp_if.source        rsp_bus
);
   import alist_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int LEVELS = (IDX_W + TREE_RADIX_LOG2 - 1) / TREE_RADIX_LOG2;

   alist_cmd_type    cmd;
   alist_status_type status;
   logic             req_ready;

   // sequencer: accept, lookup steps, update
   alist_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // cells, parallel compare, first-match tree and result register
   alist_dpath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_bus.kind),
      .req_key         (req_bus.key),
      .req_position    (req_bus.position),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_failed      (rsp_bus.failed),
      .rsp_found_index (rsp_bus.found_index),
      .rsp_entry_count (rsp_bus.entry_count)
   );

endmodule
